// File: src/spro_pkg.sv
// Shared widths, register indexes and status type for the sieve root/offset block.
package spro_pkg;

    // Fixed field widths.
    localparam int MOD_W   = 31;
    localparam int LL_W    = 64;
    localparam int FIELD_W = 32;

    // Bit counter wide enough to hold the longest dividend length.
    localparam int CNT_W = 7;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [MOD_W-1:0] WHEEL_RESET = 31'd2310;
    localparam logic [LL_W-1:0]  LOWER_RESET = 64'd0;

    // Status that the core reports to the stream wrapper.
    typedef struct packed {
        logic idle;
        logic done;
    } spro_stat_t;

endpackage

// File: src/spro_alu.sv
// Shared compare/subtract unit: one magnitude subtractor and one signed coefficient subtractor.
module spro_alu #(
    parameter int W = 32
) (
    input  logic [W:0]          a_m,
    input  logic [W:0]          a_s,
    input  logic signed [W+1:0] c_m,
    input  logic signed [W+1:0] c_s,
    output logic                ge,
    output logic [W:0]          diff,
    output logic signed [W+1:0] cdiff
);

    logic [W+1:0] wide_diff;

    // The borrow out of the extended subtraction gives the compare result.
    assign wide_diff = {1'b0, a_m} - {1'b0, a_s};
    assign ge        = ~wide_diff[W+1];
    assign diff      = wide_diff[W:0];

    // Coefficient track of the extended Euclidean steps.
    assign cdiff = c_m - c_s;

endmodule

// File: src/spro_core.sv
// Sequencer and data registers: two restoring remainders and a shift-subtract extended Euclid.
module spro_core #(
    parameter int W = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [W-1:0]                prime,
    input  logic [spro_pkg::MOD_W-1:0]  wheel,
    input  logic [spro_pkg::LL_W-1:0]   lower,
    input  logic                        take,
    output spro_pkg::spro_stat_t        stat,
    output logic [W-1:0]                root,
    output logic [W-1:0]                residue
);
    import spro_pkg::*;

    localparam int KW = $clog2(W);

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MODW   = 3'd1;
    localparam logic [2:0] S_ALIGN  = 3'd2;
    localparam logic [2:0] S_REDUCE = 3'd3;
    localparam logic [2:0] S_INV    = 3'd4;
    localparam logic [2:0] S_ROOT   = 3'd5;
    localparam logic [2:0] S_MODL   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [W-1:0]        p_reg, p_next;
    logic [LL_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        r0_reg, r0_next;
    logic [W-1:0]        r1_reg, r1_next;
    logic [W:0]          s_reg, s_next;
    logic signed [W+1:0] t0_reg, t0_next;
    logic signed [W+1:0] t1_reg, t1_next;
    logic signed [W+1:0] ts_reg, ts_next;
    logic [KW-1:0]       k_reg, k_next;

    logic [W:0]          a_m, a_s, diff;
    logic signed [W+1:0] c_m, c_s, cdiff;
    logic                ge;
    logic [W-1:0]        rem_step;
    logic [W-1:0]        nr0;
    logic signed [W+1:0] nt0;

    spro_alu #(.W(W)) u_alu (
        .a_m   (a_m),
        .a_s   (a_s),
        .c_m   (c_m),
        .c_s   (c_s),
        .ge    (ge),
        .diff  (diff),
        .cdiff (cdiff)
    );

    // Operand selection for the shared unit.
    always_comb
    begin
        a_m = '0;
        a_s = '0;
        c_m = '0;
        c_s = '0;
        case (state_reg)
            S_MODW, S_MODL:
            begin
                a_m = {rem_reg, dvd_reg[LL_W-1]};
                a_s = {1'b0, p_reg};
            end
            S_ALIGN:
            begin
                a_m = {1'b0, r0_reg};
                a_s = {s_reg[W-1:0], 1'b0};
            end
            S_REDUCE:
            begin
                a_m = {1'b0, r0_reg};
                a_s = s_reg;
                c_m = t0_reg;
                c_s = ts_reg;
            end
            S_INV:
            begin
                c_m = t0_reg;
                c_s = -$signed({2'b00, p_reg});
            end
            S_ROOT:
            begin
                a_m = {1'b0, p_reg};
                a_s = {1'b0, r1_reg};
            end
            default:
            begin
                a_m = '0;
            end
        endcase
    end

    // One restoring remainder step; both outcomes stay below the prime.
    assign rem_step = ge ? diff[W-1:0] : a_m[W-1:0];

    // One shift-subtract step of the Euclidean reduction.
    assign nr0 = ge ? diff[W-1:0] : r0_reg;
    assign nt0 = ge ? cdiff : t0_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        s_next     = s_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        ts_next    = ts_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    p_next = prime;
                    if (prime == '0)
                    begin
                        r0_next    = '0;
                        rem_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dvd_next   = {wheel, {(LL_W-MOD_W){1'b0}}};
                        cnt_next   = CNT_W'(MOD_W);
                        rem_next   = '0;
                        state_next = S_MODW;
                    end
                end
            end
            S_MODW:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[LL_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    // Start Euclid with r0 = p, r1 = wheel mod p.
                    r0_next = p_reg;
                    r1_next = rem_step;
                    t0_next = '0;
                    t1_next = (W+2)'(1);
                    s_next  = {1'b0, rem_step};
                    ts_next = (W+2)'(1);
                    k_next  = '0;
                    state_next = (rem_step == '0) ? S_INV : S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                // Double the divisor while it still fits under r0.
                if (ge)
                begin
                    s_next  = {s_reg[W-1:0], 1'b0};
                    ts_next = ts_reg <<< 1;
                    k_next  = k_reg + KW'(1);
                end
                else
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (k_reg == '0)
                begin
                    // Quotient finished: rotate the remainder sequence.
                    r0_next = r1_reg;
                    r1_next = nr0;
                    t0_next = t1_reg;
                    t1_next = nt0;
                    s_next  = {1'b0, nr0};
                    ts_next = nt0;
                    state_next = (nr0 == '0) ? S_INV : S_ALIGN;
                end
                else
                begin
                    r0_next = nr0;
                    t0_next = nt0;
                    s_next  = s_reg >> 1;
                    ts_next = ts_reg >>> 1;
                    k_next  = k_reg - KW'(1);
                end
            end
            S_INV:
            begin
                // No inverse unless the gcd is one; fold a negative coefficient into range.
                if (r0_reg != W'(1))
                begin
                    r1_next = '0;
                end
                else if (t0_reg[W+1])
                begin
                    r1_next = cdiff[W-1:0];
                end
                else
                begin
                    r1_next = t0_reg[W-1:0];
                end
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                r0_next    = diff[W-1:0];
                dvd_next   = lower + LL_W'(1);
                cnt_next   = CNT_W'(LL_W);
                rem_next   = '0;
                state_next = S_MODL;
            end
            S_MODL:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[LL_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        s_reg   <= s_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        ts_reg  <= ts_next;
        k_reg   <= k_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign root      = r0_reg;
    assign residue   = rem_reg;

endmodule

// File: src/sieve_prime_root_offset.sv
// Each word is reduced: wheel modulus mod the prime bit by bit, a shift-subtract extended Euclid
// (skipped when the wheel modulus reduces to zero), the inverse and root, then lower + 1 mod the
// prime, all on the single shared subtract/compare unit; a zero prime goes straight to the result.
// Throughput: one word at a time; a new word is taken once the core hands its result onward.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and restores the
// wheel modulus to 2310 and the lower limit to 0.
module sieve_prime_root_offset #(
    parameter int PRIME_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [spro_pkg::FIELD_W-1:0]      s_axis_tdata,   // [31:0] prime
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*spro_pkg::FIELD_W-1:0]    m_axis_tdata,   // [31:0] root, [63:32] start_residue
    input  logic                              cfg_we,
    input  logic [spro_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spro_pkg::LL_W-1:0]         cfg_data
);
    import spro_pkg::*;

    logic [MOD_W-1:0]       wheel_reg;
    logic [LL_W-1:0]        lower_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [2*FIELD_W-1:0]   out_data_reg, out_data_next;
    spro_stat_t             stat;
    logic                   out_load;
    logic                   core_start;
    logic [PRIME_WIDTH-1:0] core_root;
    logic [PRIME_WIDTH-1:0] core_residue;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg <= WHEEL_RESET;
            lower_reg <= LOWER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WHEEL: wheel_reg <= cfg_data[MOD_W-1:0];
                REG_LOWER: lower_reg <= cfg_data;
                default:   wheel_reg <= wheel_reg;
            endcase
        end
    end

    // Input handshake: only an idle core takes a word.
    assign s_axis_tready = stat.idle;
    assign core_start    = s_axis_tvalid & stat.idle;

    // The output register takes a finished result whenever it is empty or being drained.
    assign out_load = stat.done & (~out_valid_reg | m_axis_tready);

    spro_core #(.W(PRIME_WIDTH)) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (core_start),
        .prime   (s_axis_tdata[PRIME_WIDTH-1:0]),
        .wheel   (wheel_reg),
        .lower   (lower_reg),
        .take    (out_load),
        .stat    (stat),
        .root    (core_root),
        .residue (core_residue)
    );

    // Output register next values.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {FIELD_W'(core_residue), FIELD_W'(core_root)};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // A result handed over by the core shows up on the output.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("result taken from core did not reach the output");

    // An accepted word keeps the core busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // No new word is taken while the core still holds a result.
    a_no_accept_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !s_axis_tready)
        else $error("input ready while core result pending");
`endif

endmodule

// File: dv/spro_offset_checker.sv
// Checker that predicts and compares the root and start residue of every prime word.
module spro_offset_checker #(
    parameter int PRIME_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [spro_pkg::FIELD_W-1:0]      s_axis_tdata,   // [31:0] prime
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [2*spro_pkg::FIELD_W-1:0]    m_axis_tdata,   // [31:0] root, [63:32] start_residue
    input  logic                              cfg_we,
    input  logic [spro_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spro_pkg::LL_W-1:0]         cfg_data,
    output int                                pending_words,
    output int                                mismatch_count
);
    import spro_pkg::*;

    // One predicted result word, kept with the prime that caused it.
    typedef struct {
        logic [FIELD_W-1:0] prime;
        logic [FIELD_W-1:0] root;
        logic [FIELD_W-1:0] start_residue;
    } offsets_t;

    logic [MOD_W-1:0] wheel_model;
    logic [LL_W-1:0]  lower_model;
    offsets_t         expected_offsets[$];

    // Extended Euclid: inverse of a modulo p, or zero when the two share a factor.
    function automatic logic [63:0] inverse_of_wheel(input logic [63:0] a, input logic [63:0] p);
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] q;
        longint      t0;
        longint      t1;
        longint      t2;
        r0 = p;
        r1 = a % p;
        t0 = 0;
        t1 = 1;
        while (r1 != 64'd0)
        begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            // The quotient times the coefficient never exceeds p, so this cannot overflow.
            t2 = t0 - longint'(q) * t1;
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        if (r0 != 64'd1)
            return 64'd0;
        if (t0 < 0)
            return 64'(t0 + longint'(p));
        return 64'(t0);
    endfunction

    // Expected result word for one prime under the current register settings.
    function automatic offsets_t predict_offsets(input logic [FIELD_W-1:0] prime_in);
        logic [63:0] p;
        logic [63:0] inv;
        logic [63:0] diff;
        logic [63:0] next_start;
        logic [63:0] residue;
        offsets_t    o;
        p = 64'(prime_in) & ((64'd1 << PRIME_WIDTH) - 64'd1);
        o.prime = prime_in;
        o.root = '0;
        o.start_residue = '0;
        if (p != 64'd0)
        begin
            inv = inverse_of_wheel(64'(wheel_model), p);
            diff = p - inv;
            // The sum wraps at 64 bits, so the top lower limit gives a zero residue.
            next_start = lower_model + 64'd1;
            residue = next_start % p;
            o.root = diff[FIELD_W-1:0];
            o.start_residue = residue[FIELD_W-1:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: offset check: %s", $time, msg);
        mismatch_count++;
    endtask

    // Track register writes, queue a prediction per accepted prime, compare each result word.
    always @(posedge clk or negedge rst_n)
    begin
        offsets_t want;
        logic [FIELD_W-1:0] got_root;
        logic [FIELD_W-1:0] got_residue;
        if (!rst_n)
        begin
            wheel_model = WHEEL_RESET;
            lower_model = LOWER_RESET;
            expected_offsets.delete();
            pending_words = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WHEEL)
                    wheel_model = cfg_data[MOD_W-1:0];
                else if (cfg_index == REG_LOWER)
                    lower_model = cfg_data;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got_root = m_axis_tdata[FIELD_W-1:0];
                got_residue = m_axis_tdata[2*FIELD_W-1:FIELD_W];
                if (expected_offsets.size() == 0)
                    report_mismatch($sformatf("result word %h with no prime outstanding",
                                              m_axis_tdata));
                else
                begin
                    want = expected_offsets.pop_front();
                    if (got_root !== want.root)
                        report_mismatch($sformatf("prime %0d: root %0d, expected %0d",
                                                  want.prime, got_root, want.root));
                    if (got_residue !== want.start_residue)
                        report_mismatch($sformatf("prime %0d: start residue %0d, expected %0d",
                                                  want.prime, got_residue, want.start_residue));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_offsets.push_back(predict_offsets(s_axis_tdata));

            pending_words = expected_offsets.size();
        end
    end

endmodule

// File: dv/tb_sieve_prime_root_offset.sv
// Testbench top: drives prime words and register writes into the block and gives the verdict.
module tb_sieve_prime_root_offset;
    import spro_pkg::*;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 2'd3;

    localparam int PHASE_WORDS = 235;
    localparam int NUM_PHASES  = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [FIELD_W-1:0]     s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*FIELD_W-1:0]   m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [LL_W-1:0]        cfg_data = '0;
    logic                   idle_on = 1'b1;
    int                     pending_words;
    int                     mismatch_count;

    sieve_prime_root_offset #(
        .PRIME_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    spro_offset_checker #(
        .PRIME_WIDTH(32)
    ) u_offset_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending_words(pending_words),
        .mismatch_count(mismatch_count)
    );

    // Clock with a period of 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard limit on the run, well above the slowest correct run.
    initial
    begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver stalls at random unless idling is switched off.
    always @(negedge clk)
    begin
        m_axis_tready <= idle_on ? ($urandom_range(99) >= 17) : 1'b1;
    end

    // Offer one prime word, with random gaps before it, and wait for its handshake.
    task automatic send_prime(input logic [FIELD_W-1:0] prime);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= prime;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every result word has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
    endtask

    // One register write; called at a falling edge and returns at one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random prime word: full width for the largest share, with plenty of small and boundary values.
    function automatic logic [FIELD_W-1:0] pick_prime();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            return $urandom();
        else if (k < 70)
            return $urandom_range(65535, 2);
        else if (k < 88)
            return $urandom_range(400, 2);
        else if (k < 94)
        begin
            case ($urandom_range(3))
                0: return 32'd0;
                1: return 32'd1;
                2: return 32'hFFFF_FFFF;
                default: return 32'hFFFF_FFFB;
            endcase
        end
        // Multiples of small wheel primes, which have no inverse when the wheel modulus has 7 or 11 as a factor.
        return $urandom_range(3000, 1) * (($urandom_range(1)) ? 32'd7 : 32'd11);
    endfunction

    initial
    begin
        logic [FIELD_W-1:0] reset_set[$];
        logic [FIELD_W-1:0] wide_set[$];
        logic [FIELD_W-1:0] even_set[$];
        logic [LL_W-1:0]    wheel_value;
        logic [LL_W-1:0]    lower_value;

        reset_set = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17,
                      32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd65537};
        wide_set  = '{32'd2, 32'h7FFF_FFFF, 32'hFFFF_FFFB, 32'd1};
        even_set  = '{32'd2, 32'd3, 32'hFFFF_FFFF, 32'h5555_5555};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings.
        foreach (reset_set[i])
            send_prime(reset_set[i]);
        drain_results();

        // Largest wheel modulus and a lower limit that wraps to zero.
        write_reg(REG_WHEEL, 64'd2147483647);
        write_reg(REG_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
        foreach (wide_set[i])
            send_prime(wide_set[i]);
        drain_results();

        // A wheel modulus of two, one below the top lower limit, and ignored indexes.
        write_reg(REG_WHEEL, 64'd2);
        write_reg(REG_LOWER, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_NONE_LO, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_NONE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        foreach (even_set[i])
            send_prime(even_set[i]);
        drain_results();

        // Random phases, each under its own register settings.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            lower_value = {$urandom(), $urandom()};
            case (phase)
                0: wheel_value = 64'd30030;
                1:
                begin
                    wheel_value = 64'd223092870;
                    lower_value = 64'hFFFF_FFFF_FFFF_FFFF;
                end
                // Upper bits set on purpose: only the low 31 bits may count.
                2: wheel_value = {$urandom(), $urandom()};
                3:
                begin
                    wheel_value = 64'd1;
                    lower_value = 64'($urandom_range(1000));
                end
                4: wheel_value = 64'd9699690;
                5:
                begin
                    wheel_value = 64'd0;
                    lower_value = 64'd0;
                end
                6: wheel_value = 64'd2147483647;
                default: wheel_value = 64'd2310;
            endcase
            write_reg(REG_WHEEL, wheel_value);
            write_reg(REG_LOWER, lower_value);
            write_reg(($urandom_range(1)) ? REG_NONE_LO : REG_NONE_HI, {$urandom(), $urandom()});

            // One phase runs with no gaps on either side.
            idle_on <= (phase != 2);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Halfway through one phase, hold off until the pipeline is empty.
                if (phase == 4 && n == PHASE_WORDS / 2)
                    drain_results();
                send_prime(pick_prime());
            end
            drain_results();
        end

        repeat (300) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
